// ===== hdl/rfrh_pkg.sv =====
// Shared types and constants for the Raft follower request handler.
package rfrh_pkg;

    localparam int LOG_DEPTH_DEF     = 1024;
    localparam int PAYLOAD_WIDTH_DEF = 32;

    localparam int TERM_W = 32;
    localparam int IDX_W  = 10;
    localparam int ID_W   = 3;
    localparam int LDR_W  = 4;
    localparam int STAT_W = 3;

    typedef logic [STAT_W-1:0] t_status;

    localparam t_status ST_DENIED   = 3'd0;
    localparam t_status ST_GRANTED  = 3'd1;
    localparam t_status ST_OK       = 3'd2;
    localparam t_status ST_STALE    = 3'd3;
    localparam t_status ST_MISMATCH = 3'd4;
    localparam t_status ST_FULL     = 3'd5;

    localparam logic OP_VOTE   = 1'b0;
    localparam logic OP_APPEND = 1'b1;

    // voted_for / leader code for "none" or "unknown"
    localparam logic [LDR_W-1:0] NOBODY = 4'd8;

    typedef struct packed {
        logic capture;  // latch request, launch log reads
        logic execute;  // evaluate and write back
    } t_cmd;

endpackage

// ===== hdl/rfrh_ctrl.sv =====
// Sequencer for the follower request handler: accept, execute, strobe.
module rfrh_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    output logic          o_done,
    output rfrh_pkg::t_cmd o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    logic   r_done;

    always_comb begin
        o_cmd.capture = start && (r_state == S_IDLE);
        o_cmd.execute = (r_state == S_EXEC);
    end

    assign busy   = (r_state == S_EXEC);
    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= S_IDLE;
                    r_done  <= 1'b1;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_accept_to_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not enter execute");

    a_busy_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> (o_done && !busy))
        else $error("execute cycle not followed by result strobe");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without a preceding execute cycle");

endmodule

// ===== hdl/rfrh_datapath.sv =====
// Follower state, log memories and request evaluation.
module rfrh_datapath #(
    parameter int LOG_DEPTH     = rfrh_pkg::LOG_DEPTH_DEF,
    parameter int PAYLOAD_WIDTH = rfrh_pkg::PAYLOAD_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rfrh_pkg::t_cmd                 i_cmd,
    input  logic                           i_cfg_we,
    input  logic [rfrh_pkg::ID_W-1:0]      i_cfg_wdata,
    input  logic                           i_op,
    input  logic [rfrh_pkg::ID_W-1:0]      i_sender_id,
    input  logic [rfrh_pkg::TERM_W-1:0]    i_req_term,
    input  logic [rfrh_pkg::IDX_W-1:0]     i_log_index,
    input  logic [rfrh_pkg::TERM_W-1:0]    i_log_term,
    input  logic [rfrh_pkg::IDX_W-1:0]     i_leader_commit,
    input  logic                           i_has_entry,
    input  logic [rfrh_pkg::TERM_W-1:0]    i_entry_term,
    input  logic [31:0]                    i_entry_data,
    output logic [rfrh_pkg::TERM_W-1:0]    o_reply_term,
    output rfrh_pkg::t_status              o_status,
    output logic [rfrh_pkg::IDX_W-1:0]     o_last_index,
    output logic [rfrh_pkg::LDR_W-1:0]     o_known_leader
);

    localparam int AW     = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    // comparison width: holds LOG_DEPTH itself and prev+1
    localparam int CMP_W  = (AW + 1 > rfrh_pkg::IDX_W + 1) ? AW + 1 : rfrh_pkg::IDX_W + 1;
    // prev is at most 1023, so the last index reaches 1024 only on a deeper log
    localparam int LAST_W = (LOG_DEPTH > 1024) ? rfrh_pkg::IDX_W + 1 : rfrh_pkg::IDX_W;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(LOG_DEPTH);

    // log storage; entry 0 is never written and reads as term 0
    logic [rfrh_pkg::TERM_W-1:0] mem_terms [LOG_DEPTH];
    logic [PAYLOAD_WIDTH-1:0]    mem_pay   [LOG_DEPTH];

    // captured request
    logic                         r_op;
    logic [rfrh_pkg::LDR_W-1:0]   r_sender;
    logic [rfrh_pkg::TERM_W-1:0]  r_req_term;
    logic [rfrh_pkg::IDX_W-1:0]   r_prev;
    logic [rfrh_pkg::TERM_W-1:0]  r_pterm;
    logic [rfrh_pkg::IDX_W-1:0]   r_lcommit;
    logic                         r_has;
    logic [rfrh_pkg::TERM_W-1:0]  r_eterm;
    logic [PAYLOAD_WIDTH-1:0]     r_edata;
    logic [AW-1:0]                r_pos_addr;
    logic                         r_prev_zero;
    logic [rfrh_pkg::TERM_W-1:0]  r_rd_prev;
    logic [rfrh_pkg::TERM_W-1:0]  r_rd_pos;

    // follower state
    logic [rfrh_pkg::ID_W-1:0]    r_self_id;   // held for software, no effect on handling
    logic [rfrh_pkg::TERM_W-1:0]  r_cur_term;
    logic [rfrh_pkg::LDR_W-1:0]   r_voted;
    logic [rfrh_pkg::LDR_W-1:0]   r_leader;
    logic [LAST_W-1:0]            r_last_idx;
    logic [rfrh_pkg::TERM_W-1:0]  r_last_term;
    logic [rfrh_pkg::IDX_W-1:0]   r_commit;
    rfrh_pkg::t_status            r_status;

    logic [rfrh_pkg::TERM_W-1:0]  n_term;
    logic [rfrh_pkg::LDR_W-1:0]   n_voted;
    logic [rfrh_pkg::LDR_W-1:0]   n_leader;
    logic [LAST_W-1:0]            n_last_idx;
    logic [rfrh_pkg::TERM_W-1:0]  n_last_term;
    logic [rfrh_pkg::IDX_W-1:0]   n_commit;
    rfrh_pkg::t_status            n_status;
    logic                         mem_we;

    logic [CMP_W-1:0]             cap_prev_c;
    logic [CMP_W-1:0]             cap_pos_c;
    logic [CMP_W-1:0]             prev_c;
    logic [CMP_W-1:0]             pos_c;
    logic [CMP_W-1:0]             last_c;
    logic [CMP_W-1:0]             newest_c;
    logic [rfrh_pkg::IDX_W-1:0]   commit_cand;
    logic [rfrh_pkg::TERM_W-1:0]  prev_term_val;
    logic                         stale;
    logic                         newer;
    logic                         fresh;
    logic                         mismatch;
    logic                         pos_full;
    logic                         pos_exists;

    assign cap_prev_c = CMP_W'(i_log_index);
    assign cap_pos_c  = cap_prev_c + CMP_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op        <= i_op;
            r_sender    <= rfrh_pkg::LDR_W'(i_sender_id);
            r_req_term  <= i_req_term;
            r_prev      <= i_log_index;
            r_pterm     <= i_log_term;
            r_lcommit   <= i_leader_commit;
            r_has       <= i_has_entry;
            r_eterm     <= i_entry_term;
            r_edata     <= PAYLOAD_WIDTH'(i_entry_data);
            r_pos_addr  <= cap_pos_c[AW-1:0];
            r_prev_zero <= (i_log_index == '0);
            r_rd_prev   <= mem_terms[cap_prev_c[AW-1:0]];
            r_rd_pos    <= mem_terms[cap_pos_c[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_terms[r_pos_addr] <= r_eterm;
            mem_pay[r_pos_addr]   <= r_edata;
        end
    end

    always_comb begin
        prev_c        = CMP_W'(r_prev);
        pos_c         = prev_c + CMP_W'(1);
        last_c        = CMP_W'(r_last_idx);
        newest_c      = prev_c + CMP_W'(r_has);
        commit_cand   = (CMP_W'(r_lcommit) < newest_c) ? r_lcommit
                                                       : newest_c[rfrh_pkg::IDX_W-1:0];
        prev_term_val = r_prev_zero ? '0 : r_rd_prev;
        stale         = (r_req_term < r_cur_term);
        newer         = (r_req_term > r_cur_term);
        fresh         = (r_pterm > r_last_term) ||
                        ((r_pterm == r_last_term) && (prev_c >= last_c));
        mismatch      = (prev_c > last_c) || (prev_c >= DEPTH_C) ||
                        (prev_term_val != r_pterm);
        pos_full      = (pos_c >= DEPTH_C);
        pos_exists    = (pos_c <= last_c);
    end

    always_comb begin
        n_term      = r_cur_term;
        n_voted     = r_voted;
        n_leader    = r_leader;
        n_last_idx  = r_last_idx;
        n_last_term = r_last_term;
        n_commit    = r_commit;
        n_status    = rfrh_pkg::ST_DENIED;
        mem_we      = 1'b0;
        if (i_cmd.execute) begin
            if (r_op == rfrh_pkg::OP_VOTE) begin
                if (!stale) begin
                    n_term = r_req_term;
                    if (newer) begin
                        n_voted  = rfrh_pkg::NOBODY;
                        n_leader = rfrh_pkg::NOBODY;
                    end
                    if ((n_voted == rfrh_pkg::NOBODY || n_voted == r_sender) && fresh) begin
                        n_voted  = r_sender;
                        n_status = rfrh_pkg::ST_GRANTED;
                    end
                end
            end else begin
                if (stale) begin
                    n_status = rfrh_pkg::ST_STALE;
                end else begin
                    n_term = r_req_term;
                    if (newer) begin
                        n_voted = rfrh_pkg::NOBODY;
                    end
                    n_leader = r_sender;
                    if (mismatch) begin
                        n_status = rfrh_pkg::ST_MISMATCH;
                    end else if (r_has && pos_full) begin
                        n_status = rfrh_pkg::ST_FULL;
                    end else begin
                        n_status = rfrh_pkg::ST_OK;
                        // matching entry already there: leave the log alone
                        if (r_has && !(pos_exists && (r_rd_pos == r_eterm))) begin
                            mem_we      = 1'b1;
                            n_last_idx  = pos_c[LAST_W-1:0];
                            n_last_term = r_eterm;
                        end
                        if (commit_cand > r_commit) begin
                            n_commit = commit_cand;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_self_id   <= '0;
            r_cur_term  <= rfrh_pkg::TERM_W'(1);
            r_voted     <= rfrh_pkg::NOBODY;
            r_leader    <= rfrh_pkg::NOBODY;
            r_last_idx  <= '0;
            r_last_term <= '0;
            r_commit    <= '0;
            r_status    <= rfrh_pkg::ST_DENIED;
        end else begin
            if (i_cfg_we) begin
                r_self_id <= i_cfg_wdata;
            end
            if (i_cmd.execute) begin
                r_cur_term  <= n_term;
                r_voted     <= n_voted;
                r_leader    <= n_leader;
                r_last_idx  <= n_last_idx;
                r_last_term <= n_last_term;
                r_commit    <= n_commit;
                r_status    <= n_status;
            end
        end
    end

    // state only changes on execute, so it stays valid through the strobe cycle
    assign o_reply_term   = r_cur_term;
    assign o_status       = r_status;
    assign o_last_index   = r_last_idx[rfrh_pkg::IDX_W-1:0];
    assign o_known_leader = r_leader;

    a_term_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_cur_term >= $past(r_cur_term)))
        else $error("current term moved back");

    a_commit_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_commit >= $past(r_commit)))
        else $error("commit index moved back");

    a_log_change_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_last_idx != $past(r_last_idx))) |->
        (r_status == rfrh_pkg::ST_OK))
        else $error("log length changed on a request that did not succeed");

endmodule

// ===== hdl/raft_follower_request_handler_core.sv =====
// Top level of the Raft follower request handler.
// Each request (vote or append) is handled as follows: the accept cycle launches the
// registered reads of the log term memory at the previous index and the one after it,
// and the execute cycle (busy high) evaluates the request and writes state and at most
// one log entry back. The single result appears on the o_ ports with o_done high for
// exactly one cycle right after that; the receiver cannot stall it, and a new request
// may start in that same cycle, so requests are taken one at a time. Configuration
// (self_id) may be written at any edge while idle. No clearing pass follows reset;
// log entry 0 reads as term 0 by construction.
module raft_follower_request_handler_core #(
    parameter int LOG_DEPTH     = rfrh_pkg::LOG_DEPTH_DEF,
    parameter int PAYLOAD_WIDTH = rfrh_pkg::PAYLOAD_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rfrh_pkg::ID_W-1:0]      i_cfg_wdata,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_op,
    input  logic [rfrh_pkg::ID_W-1:0]      i_sender_id,
    input  logic [rfrh_pkg::TERM_W-1:0]    i_req_term,
    input  logic [rfrh_pkg::IDX_W-1:0]     i_log_index,
    input  logic [rfrh_pkg::TERM_W-1:0]    i_log_term,
    input  logic [rfrh_pkg::IDX_W-1:0]     i_leader_commit,
    input  logic                           i_has_entry,
    input  logic [rfrh_pkg::TERM_W-1:0]    i_entry_term,
    input  logic [31:0]                    i_entry_data,
    output logic                           o_done,
    output logic [rfrh_pkg::TERM_W-1:0]    o_reply_term,
    output logic [rfrh_pkg::STAT_W-1:0]    o_status,
    output logic [rfrh_pkg::IDX_W-1:0]     o_last_index,
    output logic [rfrh_pkg::LDR_W-1:0]     o_known_leader
);

    rfrh_pkg::t_cmd cmd;

    rfrh_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .o_cmd   (cmd)
    );

    rfrh_datapath #(
        .LOG_DEPTH     (LOG_DEPTH),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_op            (i_op),
        .i_sender_id     (i_sender_id),
        .i_req_term      (i_req_term),
        .i_log_index     (i_log_index),
        .i_log_term      (i_log_term),
        .i_leader_commit (i_leader_commit),
        .i_has_entry     (i_has_entry),
        .i_entry_term    (i_entry_term),
        .i_entry_data    (i_entry_data),
        .o_reply_term    (o_reply_term),
        .o_status        (o_status),
        .o_last_index    (o_last_index),
        .o_known_leader  (o_known_leader)
    );

endmodule
